// ----- rtl/slbg_pkg.sv -----
// Package: shared types, constants and mode tables for the status LED breathing generator.
package slbg_pkg;

  localparam int unsigned NumW  = 32;
  localparam int unsigned DvsW  = 20;
  localparam int unsigned StepW = 6;
  localparam int unsigned QuoW  = 8;
  localparam int unsigned MaW   = 16;
  localparam int unsigned MbW   = 10;
  localparam int unsigned AccW  = 26;
  localparam int unsigned MstW  = 4;
  localparam int unsigned PerW  = 11;
  localparam int unsigned HalfW = 10;

  localparam logic [DvsW-1:0] SmoothDiv   = 20'd65025;
  localparam logic [DvsW-1:0] ScaleDiv    = 20'd255;
  localparam logic [AccW-1:0] SmoothRound = 26'd32512;
  localparam logic [AccW-1:0] ScaleRound  = 26'd127;
  localparam logic [MbW-1:0]  SmoothK     = 10'd765;
  localparam logic [19:0]     TpmReset    = 20'd1;

  typedef enum logic [2:0] {
    CFG_TPM   = 3'd0,
    CFG_UPD   = 3'd1,
    CFG_RED   = 3'd2,
    CFG_GREEN = 3'd3,
    CFG_BLUE  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_UPD,
    MODE_OFF,
    MODE_CAL,
    MODE_NORM
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MSDIV,
    ST_XCALC,
    ST_XDIV,
    ST_SQ,
    ST_CUBE,
    ST_SDIV,
    ST_SCALE,
    ST_BDIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NumW-1:0]  num;
    logic [DvsW-1:0]  rem0;
    logic [DvsW-1:0]  divisor;
    logic [StepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            qbit_vld;
    logic            qbit;
    logic [QuoW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [MaW-1:0]  a;
    logic [MbW-1:0]  b;
    logic [AccW-1:0] acc0;
    logic [MstW-1:0] steps;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic [AccW-1:0] acc;
  } mul_rsp_t;

  function automatic logic [PerW-1:0] period_of(mode_e m);
    logic [PerW-1:0] p;
    case (m)
      MODE_UPD: p = 11'd1000;
      MODE_OFF: p = 11'd1800;
      MODE_CAL: p = 11'd1400;
      default:  p = 11'd1000;
    endcase
    return p;
  endfunction

  function automatic logic [HalfW-1:0] half_of(mode_e m);
    logic [HalfW-1:0] h;
    case (m)
      MODE_UPD: h = 10'd500;
      MODE_OFF: h = 10'd900;
      MODE_CAL: h = 10'd700;
      default:  h = 10'd500;
    endcase
    return h;
  endfunction

  function automatic logic [5:0] lo_of(mode_e m);
    logic [5:0] v;
    case (m)
      MODE_UPD: v = 6'd4;
      MODE_OFF: v = 6'd3;
      MODE_CAL: v = 6'd5;
      default:  v = 6'd4;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] hi_of(mode_e m);
    logic [5:0] v;
    case (m)
      MODE_UPD: v = 6'd48;
      MODE_OFF: v = 6'd40;
      MODE_CAL: v = 6'd48;
      default:  v = 6'd48;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/slbg_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
module slbg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slbg_pkg::div_req_t req_i,
  output slbg_pkg::div_rsp_t rsp_o
);

  logic [slbg_pkg::NumW-1:0]  num_q, num_d;
  logic [slbg_pkg::DvsW-1:0]  rem_q, rem_d;
  logic [slbg_pkg::DvsW-1:0]  dvs_q, dvs_d;
  logic [slbg_pkg::QuoW-1:0]  quo_q, quo_d;
  logic [slbg_pkg::StepW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       qbit_q, qbit_d;
  logic                       qvld_q, qvld_d;
  logic [slbg_pkg::DvsW:0]    shifted;
  logic [slbg_pkg::DvsW:0]    sub;
  logic                       qb;

  assign shifted = {rem_q, num_q[slbg_pkg::NumW-1]};
  assign sub     = shifted - {1'b0, dvs_q};
  assign qb      = (shifted >= {1'b0, dvs_q});

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    qbit_d = qbit_q;
    qvld_d = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      rem_d  = req_i.rem0;
      dvs_d  = req_i.divisor;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d  = {num_q[slbg_pkg::NumW-2:0], 1'b0};
      rem_d  = qb ? sub[slbg_pkg::DvsW-1:0] : shifted[slbg_pkg::DvsW-1:0];
      quo_d  = {quo_q[slbg_pkg::QuoW-2:0], qb};
      qbit_d = qb;
      qvld_d = 1'b1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == slbg_pkg::StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      qvld_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      qvld_q <= qvld_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    qbit_q <= qbit_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.qbit_vld = qvld_q;
  assign rsp_o.qbit     = qbit_q;
  assign rsp_o.quo      = quo_q;

endmodule

// ----- rtl/slbg_mul.sv -----
// Bit-serial shift-add multiplier with preloaded accumulator, one multiplier bit per cycle.
module slbg_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slbg_pkg::mul_req_t req_i,
  output slbg_pkg::mul_rsp_t rsp_o
);

  logic [slbg_pkg::AccW-1:0] a_q, a_d;
  logic [slbg_pkg::MbW-1:0]  b_q, b_d;
  logic [slbg_pkg::AccW-1:0] acc_q, acc_d;
  logic [slbg_pkg::MstW-1:0] cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = slbg_pkg::AccW'(req_i.a);
      b_d    = req_i.b;
      acc_d  = req_i.acc0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = {a_q[slbg_pkg::AccW-2:0], 1'b0};
      b_d   = {1'b0, b_q[slbg_pkg::MbW-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == slbg_pkg::MstW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;

endmodule

// ----- rtl/status_led_breathing_generator.sv -----
// Status LED breathing generator top: rate limiter, sequencer and output register.
// Sequence from accept to m_axis_tvalid: the normal color goes check, emit; a breathing color goes
// check, tick-to-ms divide, shaping and scaling (XCALC, XDIV, SQ, CUBE, SDIV, SCALE, BDIV), emit.
// A word is taken only in idle, so a new word waits until the last one is emitted or rejected
// (rejected: no output); emit waits while an earlier color is held by m_axis_tready, unless it repeats.
// Reset (async, active low): tick rate 1, mode normal, other control registers 0, no color known, limiter open.
module status_led_breathing_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // now_ticks[31:0], link_up, calibrating, setup_needed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  slbg_pkg::state_e state_q, state_d;
  slbg_pkg::mode_e  mode_q, mode_d, mode_c;

  logic [19:0] tpm_q;
  logic        upd_q;
  logic [7:0]  nred_q, ngrn_q, nblu_q;
  logic [31:0] last_upd_q;
  logic [23:0] last_col_q;
  logic        known_q;
  logic [31:0] now_q;
  logic        online_q, calib_q, setup_q;
  logic [23:0] cand_q, cand_d;
  logic [slbg_pkg::PerW-1:0] mod_q, mod_d;
  logic [7:0]  x_q;
  logic        mvld_q;
  logic [23:0] mdata_q;

  logic [19:0] tpm;
  logic [24:0] lim;
  logic [31:0] dt;
  logic        reject;
  logic [slbg_pkg::PerW:0]     fold;
  logic [slbg_pkg::PerW-1:0]   period;
  logic [slbg_pkg::HalfW-1:0]  half;
  logic [slbg_pkg::HalfW-1:0]  xr;
  logic [17:0] x255;
  logic [7:0]  lvl;
  logic        same;
  logic        out_free;
  logic        emit_go;

  slbg_pkg::div_req_t div_req;
  slbg_pkg::div_rsp_t div_rsp;
  slbg_pkg::mul_req_t mul_req;
  slbg_pkg::mul_rsp_t mul_rsp;

  slbg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  slbg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign tpm    = (tpm_q == '0) ? slbg_pkg::TpmReset : tpm_q;
  assign lim    = {1'b0, tpm, 4'b0} + {3'b0, tpm, 2'b0};
  assign dt     = now_q - last_upd_q;
  assign reject = (last_upd_q != '0) && (dt < {7'b0, lim});

  always_comb begin
    if (upd_q) begin
      mode_c = slbg_pkg::MODE_UPD;
    end else if (!online_q) begin
      mode_c = slbg_pkg::MODE_OFF;
    end else if (calib_q || setup_q) begin
      mode_c = slbg_pkg::MODE_CAL;
    end else begin
      mode_c = slbg_pkg::MODE_NORM;
    end
  end

  assign period = slbg_pkg::period_of(mode_q);
  assign half   = slbg_pkg::half_of(mode_q);
  assign fold   = {mod_q, div_rsp.qbit};
  assign xr     = (mod_q <= slbg_pkg::PerW'(half)) ? mod_q[slbg_pkg::HalfW-1:0]
                                                  : slbg_pkg::HalfW'(period - mod_q);
  assign x255   = {xr, 8'b0} - {8'b0, xr};
  assign lvl    = {2'b0, slbg_pkg::lo_of(mode_q)} + div_rsp.quo;
  assign same   = known_q && (cand_q == last_col_q);
  assign out_free = !mvld_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slbg_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = slbg_pkg::ST_CHECK;
      end
      slbg_pkg::ST_CHECK: begin
        if (reject) begin
          state_d = slbg_pkg::ST_IDLE;
        end else if (mode_c == slbg_pkg::MODE_NORM) begin
          state_d = slbg_pkg::ST_EMIT;
        end else begin
          state_d = slbg_pkg::ST_MSDIV;
        end
      end
      slbg_pkg::ST_MSDIV: if (div_rsp.done) state_d = slbg_pkg::ST_XCALC;
      slbg_pkg::ST_XCALC: state_d = slbg_pkg::ST_XDIV;
      slbg_pkg::ST_XDIV:  if (div_rsp.done) state_d = slbg_pkg::ST_SQ;
      slbg_pkg::ST_SQ:    if (mul_rsp.done) state_d = slbg_pkg::ST_CUBE;
      slbg_pkg::ST_CUBE:  if (mul_rsp.done) state_d = slbg_pkg::ST_SDIV;
      slbg_pkg::ST_SDIV:  if (div_rsp.done) state_d = slbg_pkg::ST_SCALE;
      slbg_pkg::ST_SCALE: if (mul_rsp.done) state_d = slbg_pkg::ST_BDIV;
      slbg_pkg::ST_BDIV:  if (div_rsp.done) state_d = slbg_pkg::ST_EMIT;
      slbg_pkg::ST_EMIT: begin
        if (same || out_free) state_d = slbg_pkg::ST_IDLE;
      end
      default: state_d = slbg_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    div_req = '0;
    mul_req = '0;
    emit_go = 1'b0;
    s_axis_tready = 1'b0;
    mode_d  = mode_q;
    cand_d  = cand_q;
    mod_d   = mod_q;
    case (state_q)
      slbg_pkg::ST_IDLE: s_axis_tready = 1'b1;
      slbg_pkg::ST_CHECK: begin
        mode_d = mode_c;
        mod_d  = '0;
        cand_d = {nblu_q, ngrn_q, nred_q};
        if (!reject && mode_c != slbg_pkg::MODE_NORM) begin
          div_req.start   = 1'b1;
          div_req.num     = now_q;
          div_req.rem0    = '0;
          div_req.divisor = tpm;
          div_req.steps   = slbg_pkg::StepW'(32);
        end
      end
      slbg_pkg::ST_MSDIV: begin
        if (div_rsp.qbit_vld) begin
          mod_d = (fold >= {1'b0, period}) ? slbg_pkg::PerW'(fold - {1'b0, period})
                                           : fold[slbg_pkg::PerW-1:0];
        end
      end
      slbg_pkg::ST_XCALC: begin
        div_req.start   = 1'b1;
        div_req.num     = {x255[7:0], 24'b0};
        div_req.rem0    = {10'b0, x255[17:8]};
        div_req.divisor = {10'b0, half};
        div_req.steps   = slbg_pkg::StepW'(8);
      end
      slbg_pkg::ST_XDIV: begin
        if (div_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {8'b0, div_rsp.quo};
          mul_req.b     = {2'b0, div_rsp.quo};
          mul_req.acc0  = '0;
          mul_req.steps = slbg_pkg::MstW'(8);
        end
      end
      slbg_pkg::ST_SQ: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.acc[15:0];
          mul_req.b     = slbg_pkg::SmoothK - {1'b0, x_q, 1'b0};
          mul_req.acc0  = slbg_pkg::SmoothRound;
          mul_req.steps = slbg_pkg::MstW'(10);
        end
      end
      slbg_pkg::ST_CUBE: begin
        if (mul_rsp.done) begin
          div_req.start   = 1'b1;
          div_req.num     = {mul_rsp.acc[7:0], 24'b0};
          div_req.rem0    = {4'b0, mul_rsp.acc[23:8]};
          div_req.divisor = slbg_pkg::SmoothDiv;
          div_req.steps   = slbg_pkg::StepW'(8);
        end
      end
      slbg_pkg::ST_SDIV: begin
        if (div_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {8'b0, div_rsp.quo};
          mul_req.b     = {4'b0, slbg_pkg::hi_of(mode_q) - slbg_pkg::lo_of(mode_q)};
          mul_req.acc0  = slbg_pkg::ScaleRound;
          mul_req.steps = slbg_pkg::MstW'(6);
        end
      end
      slbg_pkg::ST_SCALE: begin
        if (mul_rsp.done) begin
          div_req.start   = 1'b1;
          div_req.num     = {mul_rsp.acc[7:0], 24'b0};
          div_req.rem0    = {2'b0, mul_rsp.acc[25:8]};
          div_req.divisor = slbg_pkg::ScaleDiv;
          div_req.steps   = slbg_pkg::StepW'(8);
        end
      end
      slbg_pkg::ST_BDIV: begin
        if (div_rsp.done) begin
          case (mode_q)
            slbg_pkg::MODE_UPD: cand_d = {lvl, 1'b0, lvl[7:1], 8'b0};
            slbg_pkg::MODE_OFF: cand_d = {16'b0, lvl};
            slbg_pkg::MODE_CAL: cand_d = {8'b0, lvl, lvl};
            default:            cand_d = cand_q;
          endcase
        end
      end
      slbg_pkg::ST_EMIT: emit_go = !same && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= slbg_pkg::ST_IDLE;
      mode_q     <= slbg_pkg::MODE_NORM;
      tpm_q      <= slbg_pkg::TpmReset;
      upd_q      <= 1'b0;
      nred_q     <= '0;
      ngrn_q     <= '0;
      nblu_q     <= '0;
      last_upd_q <= '0;
      last_col_q <= '0;
      known_q    <= 1'b0;
      mvld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          slbg_pkg::CFG_TPM: tpm_q <= cfg_data_i;
          slbg_pkg::CFG_UPD: upd_q <= cfg_data_i[0];
          slbg_pkg::CFG_RED: begin
            nred_q  <= cfg_data_i[7:0];
            known_q <= 1'b0;
          end
          slbg_pkg::CFG_GREEN: begin
            ngrn_q  <= cfg_data_i[7:0];
            known_q <= 1'b0;
          end
          slbg_pkg::CFG_BLUE: begin
            nblu_q  <= cfg_data_i[7:0];
            known_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_q == slbg_pkg::ST_CHECK && !reject) begin
        last_upd_q <= now_q;
      end
      if (emit_go) begin
        last_col_q <= cand_q;
        known_q    <= 1'b1;
        mvld_q     <= 1'b1;
      end else if (m_axis_tready) begin
        mvld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      now_q    <= s_axis_tdata[31:0];
      online_q <= s_axis_tdata[32];
      calib_q  <= s_axis_tdata[33];
      setup_q  <= s_axis_tdata[34];
    end
    cand_q <= cand_d;
    mod_q  <= mod_d;
    if (state_q == slbg_pkg::ST_XDIV && div_rsp.done) begin
      x_q <= div_rsp.quo;
    end
    if (emit_go) begin
      mdata_q <= cand_q;
    end
  end

  assign m_axis_tvalid = mvld_q;
  assign m_axis_tdata  = mdata_q;
  assign cfg_ready_o   = 1'b1;

endmodule
